[sv/rsb_pkg.sv]
package rsb_pkg;

  localparam int unsigned SCREEN_DIM = 2048;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_KEY   = 3'd4;

  localparam logic       ACT_BEGIN = 1'b0;
  localparam logic       ACT_DATA  = 1'b1;

  localparam logic [1:0] TINT_NONE    = 2'd0;
  localparam logic [1:0] TINT_REPLACE = 2'd1;

  localparam logic [7:0] CTRL_SKIP = 8'd255;
  localparam logic [7:0] CTRL_EOL  = 8'd0;

  typedef struct packed {
    logic              action;
    logic [7:0]        data_byte;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [9:0]        sprite_width;
    logic [9:0]        sprite_rows;
    logic              run_coded;
    logic [1:0]        tint_mode;
    logic [15:0]       tint_color;
  } rsb_in_t;

  typedef struct packed {
    logic [10:0] screen_x;
    logic [10:0] screen_y;
    logic [23:0] rgb;
  } rsb_out_t;

  // result of clipping one axis
  typedef struct packed {
    logic       visible;
    logic [9:0] cut_lo;
    logic [9:0] lim_hi;
  } rsb_axis_t;

  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

endpackage

[sv/rsb_clip_axis.sv]
module rsb_clip_axis (
  input  logic signed [11:0] org,
  input  logic [9:0]         len,
  input  logic [10:0]        lo,
  input  logic [11:0]        hi,
  output rsb_pkg::rsb_axis_t axis
);

  logic [11:0]        hi_sat;
  logic signed [13:0] org_e;
  logic signed [13:0] end_e;
  logic signed [13:0] lo_e;
  logic signed [13:0] hi_e;
  logic signed [13:0] cut_lo_e;
  logic signed [13:0] lim_e;

  // edges past the screen saturate
  assign hi_sat = (hi > 12'(rsb_pkg::SCREEN_DIM)) ? 12'(rsb_pkg::SCREEN_DIM) : hi;

  assign org_e    = 14'(org);
  assign end_e    = org_e + $signed({4'b0, len});
  assign lo_e     = $signed({3'b0, lo});
  assign hi_e     = $signed({2'b0, hi_sat});
  assign cut_lo_e = lo_e - org_e;
  assign lim_e    = hi_e - org_e;

  always_comb begin
    axis.visible = (len != 10'd0) && (end_e > lo_e) && (org_e < hi_e);
    axis.cut_lo  = (org_e < lo_e) ? cut_lo_e[9:0] : 10'd0;
    // first sprite index past the far edge
    axis.lim_hi  = (end_e > hi_e) ? lim_e[9:0] : len;
  end

endmodule

[sv/rle_sprite_blitter_with_clip_core.sv]
// channel  | ports                          | payload
// ---------+--------------------------------+------------------------------
// input    | in_valid / in_ready / in_data  | rsb_in_t: begin header or byte
// result   | out_valid / out_ready / out_data | rsb_out_t: one screen write
// config   | cfg_we / cfg_index / cfg_wdata | clip edges, transparent key
//
// one item per cycle while the result is not stalled: an item is held in the
// input register, is parsed and clipped there, and its pixel (if any) lands
// in the result register.
// a stalled result holds the input register; the input side keeps flowing
// while the result register is empty or being taken.
// rst_n is synchronous: clears the sprite state and loads register defaults.
module rle_sprite_blitter_with_clip_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rsb_pkg::rsb_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rsb_pkg::rsb_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;
  localparam logic [1:0] PH_HI   = 2'd3;

  // configuration
  logic [10:0] clip_left_r;
  logic [11:0] clip_right_r;
  logic [10:0] clip_top_r;
  logic [11:0] clip_bottom_r;
  logic [15:0] trans_key_r;

  // pipeline
  logic              s1_valid_r;
  rsb_pkg::rsb_in_t  s1_item_r;
  logic              out_valid_r;
  rsb_pkg::rsb_out_t out_data_r;
  logic              adv;
  logic              fire;

  // sprite state
  logic               active_r, active_nxt;
  logic               coded_r, coded_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [15:0]        tint_r, tint_nxt;
  logic signed [11:0] ox_r, ox_nxt;
  logic signed [11:0] oy_r, oy_nxt;
  logic [9:0]         width_r, width_nxt;
  logic [9:0]         cut_l_r, cut_l_nxt;
  logic [9:0]         col_lim_r, col_lim_nxt;
  logic [9:0]         cut_t_r, cut_t_nxt;
  logic [9:0]         row_lim_r, row_lim_nxt;
  logic [10:0]        col_r, col_nxt;
  logic [9:0]         row_r, row_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [7:0]         run_r, run_nxt;
  logic [7:0]         low_r, low_nxt;

  rsb_pkg::rsb_axis_t ax_x;
  rsb_pkg::rsb_axis_t ax_y;

  logic [7:0]  b;
  logic [15:0] pix;
  logic [15:0] color;
  logic        pix_try;
  logic        eor;
  logic        emit;
  logic [10:0] col_new;
  logic [11:0] skip_sum;
  logic [7:0]  run_dec;
  logic [9:0]  row_inc;
  rsb_pkg::rsb_out_t res;

  rsb_clip_axis u_clip_x (
    .org  (s1_item_r.origin_x),
    .len  (s1_item_r.sprite_width),
    .lo   (clip_left_r),
    .hi   (clip_right_r),
    .axis (ax_x)
  );

  rsb_clip_axis u_clip_y (
    .org  (s1_item_r.origin_y),
    .len  (s1_item_r.sprite_rows),
    .lo   (clip_top_r),
    .hi   (clip_bottom_r),
    .axis (ax_y)
  );

  assign adv       = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && adv;
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = s1_item_r.data_byte;
  assign pix      = {b, low_r};
  assign skip_sum = {1'b0, col_r} + {4'b0, b};
  assign run_dec  = run_r - 8'd1;
  assign row_inc  = row_r + 10'd1;

  always_comb begin
    active_nxt  = active_r;
    coded_nxt   = coded_r;
    mode_nxt    = mode_r;
    tint_nxt    = tint_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    width_nxt   = width_r;
    cut_l_nxt   = cut_l_r;
    col_lim_nxt = col_lim_r;
    cut_t_nxt   = cut_t_r;
    row_lim_nxt = row_lim_r;
    row_nxt     = row_r;
    phase_nxt   = phase_r;
    run_nxt     = run_r;
    low_nxt     = low_r;
    col_new     = col_r;
    pix_try     = 1'b0;
    eor         = 1'b0;

    if (s1_item_r.action == rsb_pkg::ACT_BEGIN) begin
      active_nxt  = ax_x.visible && ax_y.visible;
      coded_nxt   = s1_item_r.run_coded;
      mode_nxt    = s1_item_r.tint_mode;
      tint_nxt    = s1_item_r.tint_color;
      ox_nxt      = s1_item_r.origin_x;
      oy_nxt      = s1_item_r.origin_y;
      width_nxt   = s1_item_r.sprite_width;
      cut_l_nxt   = ax_x.cut_lo;
      col_lim_nxt = ax_x.lim_hi;
      cut_t_nxt   = ax_y.cut_lo;
      row_lim_nxt = ax_y.lim_hi;
      col_new     = 11'd0;
      row_nxt     = 10'd0;
      run_nxt     = 8'd0;
      low_nxt     = 8'd0;
      phase_nxt   = s1_item_r.run_coded ? PH_CTRL : PH_LO;
    end else if (active_r) begin
      if (!coded_r) begin
        if (phase_r != PH_HI) begin
          low_nxt   = b;
          phase_nxt = PH_HI;
        end else begin
          pix_try   = (pix != trans_key_r);
          col_new   = col_r + 11'd1;
          phase_nxt = PH_LO;
          eor       = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_CTRL: begin
            if (b == rsb_pkg::CTRL_SKIP) begin
              phase_nxt = PH_SKIP;
            end else if (b == rsb_pkg::CTRL_EOL) begin
              eor = 1'b1;
            end else begin
              run_nxt   = b;
              phase_nxt = PH_LO;
            end
          end
          PH_SKIP: begin
            col_new   = skip_sum[11] ? 11'h7FF : skip_sum[10:0];
            phase_nxt = PH_CTRL;
            eor       = 1'b1;
          end
          PH_LO: begin
            low_nxt   = b;
            phase_nxt = PH_HI;
          end
          PH_HI: begin
            pix_try = 1'b1;
            col_new = col_r + 11'd1;
            run_nxt = run_dec;
            if (run_dec == 8'd0) begin
              phase_nxt = PH_CTRL;
              eor       = 1'b1;
            end else begin
              phase_nxt = PH_LO;
            end
          end
          default: phase_nxt = PH_CTRL;
        endcase
      end
    end

    col_nxt = col_new;
    // row ends once the column reaches the sprite width
    if (eor && (col_new >= {1'b0, width_r})) begin
      col_nxt = 11'd0;
      row_nxt = row_inc;
      if (row_inc >= row_lim_r) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    case (mode_r)
      rsb_pkg::TINT_NONE:    color = pix;
      rsb_pkg::TINT_REPLACE: color = tint_r;
      default:               color = tint_r & pix;
    endcase
    emit = pix_try && (row_r >= cut_t_r) && (col_r >= {1'b0, cut_l_r}) &&
           (col_r < {1'b0, col_lim_r});
    res.screen_x = ox_r[10:0] + col_r;
    res.screen_y = oy_r[10:0] + {1'b0, row_r};
    res.rgb      = rsb_pkg::expand565(color);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= 11'd0;
      clip_right_r  <= 12'd800;
      clip_top_r    <= 11'd0;
      clip_bottom_r <= 12'd600;
      trans_key_r   <= 16'hF81F;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsb_pkg::REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata[10:0];
        rsb_pkg::REG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata[11:0];
        rsb_pkg::REG_CLIP_TOP:    clip_top_r    <= cfg_wdata[10:0];
        rsb_pkg::REG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata[11:0];
        rsb_pkg::REG_TRANS_KEY:   trans_key_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      coded_r     <= 1'b0;
      mode_r      <= 2'd0;
      tint_r      <= 16'd0;
      ox_r        <= 12'sd0;
      oy_r        <= 12'sd0;
      width_r     <= 10'd0;
      cut_l_r     <= 10'd0;
      col_lim_r   <= 10'd0;
      cut_t_r     <= 10'd0;
      row_lim_r   <= 10'd0;
      col_r       <= 11'd0;
      row_r       <= 10'd0;
      phase_r     <= PH_CTRL;
      run_r       <= 8'd0;
      low_r       <= 8'd0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= fire && emit;
      end
      if (fire) begin
        active_r  <= active_nxt;
        coded_r   <= coded_nxt;
        mode_r    <= mode_nxt;
        tint_r    <= tint_nxt;
        ox_r      <= ox_nxt;
        oy_r      <= oy_nxt;
        width_r   <= width_nxt;
        cut_l_r   <= cut_l_nxt;
        col_lim_r <= col_lim_nxt;
        cut_t_r   <= cut_t_nxt;
        row_lim_r <= row_lim_nxt;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        phase_r   <= phase_nxt;
        run_r     <= run_nxt;
        low_r     <= low_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (fire && emit) begin
      out_data_r <= res;
    end
  end

  // a begin item restarts the sprite at its first column and row
  a_begin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (s1_item_r.action == rsb_pkg::ACT_BEGIN) |=> (col_r == 11'd0) && (row_r == 10'd0))
    else $error("begin item did not reset position");

  // bytes for an idle block give no pixel
  a_idle_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (s1_item_r.action == rsb_pkg::ACT_DATA) && !active_r |=> !out_valid_r)
    else $error("pixel emitted while idle");

  // while drawing, the row never reaches the clipped bottom
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (row_r < row_lim_r))
    else $error("active past clipped bottom");

  // a result that is not taken stays put
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

endmodule
